>>> hw/rtl/h2r_pkg.sv
// Shared types and hue constants for the HSL to RGB converter.
package h2r_pkg;

  localparam int HUE_W = 15;
  localparam int KW    = 12;

  localparam logic [HUE_W-1:0] DEG60  = 15'd3840;
  localparam logic [HUE_W-1:0] DEG120 = 15'd7680;
  localparam logic [HUE_W-1:0] DEG180 = 15'd11520;
  localparam logic [HUE_W-1:0] DEG240 = 15'd15360;
  localparam logic [HUE_W-1:0] DEG300 = 15'd19200;
  localparam logic [HUE_W-1:0] DEG360 = 15'd23040;

  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

endpackage

>>> hw/rtl/hsl_to_rgb_converter_top.sv
// Top level of the pipelined HSL to RGB converter.
//
// One command channel in: hue (Q9.6 degrees), saturation, lightness and
// alpha_in are transferred at a rising edge where start is high and busy
// is low. busy is tied low, so a new colour may be transferred every cycle.
// One result channel out: red, green, blue and alpha_out are valid for
// exactly one cycle while done is high. The receiver cannot hold results
// off; every accepted colour produces exactly one result, in order.
// The path from the transfer edge to done runs through seven register
// stages (input, hue sector, chroma multiply, secondary multiply, sum,
// divide by fifteen, output). Throughput: one colour per cycle, since
// every stage takes a new item in each cycle.
// Hue at or above 360 degrees is reduced once by 360. Fractions above one
// are saturated to one; channels are rounded half up and clamped to one.
// Reset (rst, synchronous) clears the stage valid bits and done; the data
// registers are not reset, and items in flight at reset are dropped.
module hsl_to_rgb_converter_top import h2r_pkg::*; #(
  parameter int CHANNEL_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [HUE_W-1:0]             hue,
  input  logic [CHANNEL_FRAC_BITS:0]   saturation,
  input  logic [CHANNEL_FRAC_BITS:0]   lightness,
  input  logic [CHANNEL_FRAC_BITS:0]   alpha_in,
  output logic                         done,
  output logic [CHANNEL_FRAC_BITS:0]   red,
  output logic [CHANNEL_FRAC_BITS:0]   green,
  output logic [CHANNEL_FRAC_BITS:0]   blue,
  output logic [CHANNEL_FRAC_BITS:0]   alpha_out
);

  localparam int F   = CHANNEL_FRAC_BITS;
  localparam int CW  = F + 1;
  localparam int CNW = 2 * F + 1;
  localparam int KCW = 2 * F + 12;
  localparam int BW  = 2 * F + 2;
  localparam int YNW = 2 * F + 13;
  localparam int YW  = F + 5;
  localparam int QW  = YW - 3;
  localparam logic [CW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic accept;

  // stage A: wrapped hue, saturated fractions
  logic             a_vld;
  logic [HUE_W-1:0] a_hue;
  logic [CW-1:0]    a_sat, a_lit, a_alp;

  // stage B: sector, ramp, 1 - |2L - 1|
  logic          b_vld;
  sector_t       b_sector;
  logic [KW-1:0] b_k;
  logic [CW-1:0] b_omd, b_sat, b_lit, b_alp;

  // stage C: chroma
  logic           c_vld;
  sector_t        c_sector;
  logic [KW-1:0]  c_k;
  logic [CNW-1:0] c_cnum;
  logic [CW-1:0]  c_lit, c_alp;

  // stage D: secondary product, base
  logic           d_vld;
  sector_t        d_sector;
  logic [KCW-1:0] d_kc;
  logic [BW-1:0]  d_base;
  logic [CNW-1:0] d_cnum;
  logic [CW-1:0]  d_alp;

  // stage E: rounded sums
  logic          e_vld;
  sector_t       e_sector;
  logic [YW-1:0] e_y;
  logic [CW-1:0] e_z, e_c;
  logic [CW-1:0] e_alp;

  // stage F: divided secondary
  logic          f_vld;
  sector_t       f_sector;
  logic [QW-1:0] f_x;
  logic [CW-1:0] f_z, f_c;
  logic [CW-1:0] f_alp;

  logic [HUE_W-1:0] hue_w;
  logic [CW-1:0]    sat_s, lit_s, alp_s;

  sector_t          sector_w;
  logic [HUE_W-1:0] t_w, dt_w;
  logic [KW-1:0]    k_w;
  logic [CW:0]      two_l, one2, span;
  logic [CW-1:0]    omd_w;

  logic [2*CW-1:0]  cnum_full;
  logic [KCW-1:0]   kc_w;
  logic [BW-1:0]    base_w;
  logic [BW-1:0]    sum_z, sum_c;
  logic [YNW-1:0]   ynum;

  logic [CW-1:0]    xc, cc, zc;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage A
  always_comb begin
    hue_w = (hue >= DEG360) ? hue - DEG360 : hue;
    sat_s = (saturation > ONE) ? ONE : saturation;
    lit_s = (lightness > ONE) ? ONE : lightness;
    alp_s = (alpha_in > ONE) ? ONE : alpha_in;
  end

  always_ff @(posedge clk) begin
    a_hue <= hue_w;
    a_sat <= sat_s;
    a_lit <= lit_s;
    a_alp <= alp_s;
  end

  // stage B
  always_comb begin
    if (a_hue < DEG60) begin
      sector_w = SEC_RY;
    end else if (a_hue < DEG120) begin
      sector_w = SEC_YG;
    end else if (a_hue < DEG180) begin
      sector_w = SEC_GC;
    end else if (a_hue < DEG240) begin
      sector_w = SEC_CB;
    end else if (a_hue < DEG300) begin
      sector_w = SEC_BM;
    end else begin
      sector_w = SEC_MR;
    end
    if (a_hue < DEG120) begin
      t_w = a_hue;
    end else if (a_hue < DEG240) begin
      t_w = a_hue - DEG120;
    end else begin
      t_w = a_hue - DEG240;
    end
    dt_w  = (t_w >= DEG60) ? t_w - DEG60 : DEG60 - t_w;
    k_w   = KW'(DEG60 - dt_w);
    two_l = {a_lit, 1'b0};
    one2  = {1'b0, ONE};
    span  = (two_l >= one2) ? two_l - one2 : one2 - two_l;
    omd_w = CW'(one2 - span);
  end

  always_ff @(posedge clk) begin
    b_sector <= sector_w;
    b_k      <= k_w;
    b_omd    <= omd_w;
    b_sat    <= a_sat;
    b_lit    <= a_lit;
    b_alp    <= a_alp;
  end

  // stage C
  assign cnum_full = (2*CW)'(b_omd) * (2*CW)'(b_sat);

  always_ff @(posedge clk) begin
    c_sector <= b_sector;
    c_k      <= b_k;
    c_cnum   <= cnum_full[CNW-1:0];
    c_lit    <= b_lit;
    c_alp    <= b_alp;
  end

  // stage D
  assign kc_w   = KCW'(c_k) * KCW'(c_cnum);
  assign base_w = (BW'(c_lit) << (F + 1)) - BW'(c_cnum);

  always_ff @(posedge clk) begin
    d_sector <= c_sector;
    d_kc     <= kc_w;
    d_base   <= base_w;
    d_cnum   <= c_cnum;
    d_alp    <= c_alp;
  end

  // stage E: 1920 * (base + one) + k * cnum over 3840 * one
  always_comb begin
    sum_z = d_base + BW'(ONE);
    sum_c = d_base + (BW'(d_cnum) << 1) + BW'(ONE);
    ynum  = (YNW'(sum_z) << 11) - (YNW'(sum_z) << 7) + YNW'(d_kc);
  end

  always_ff @(posedge clk) begin
    e_sector <= d_sector;
    e_y      <= ynum[YNW-1:F+8];
    e_z      <= sum_z[BW-1:F+1];
    e_c      <= sum_c[BW-1:F+1];
    e_alp    <= d_alp;
  end

  // stage F
  h2r_div15 #(
    .YW (YW)
  ) u_div15 (
    .clk (clk),
    .y   (e_y),
    .q   (f_x)
  );

  always_ff @(posedge clk) begin
    f_sector <= e_sector;
    f_z      <= e_z;
    f_c      <= e_c;
    f_alp    <= e_alp;
  end

  // stage G: clamp and place by sector
  always_comb begin
    xc = (f_x > QW'(ONE)) ? ONE : f_x[CW-1:0];
    cc = (f_c > ONE) ? ONE : f_c;
    zc = (f_z > ONE) ? ONE : f_z;
  end

  always_ff @(posedge clk) begin
    unique case (f_sector)
      SEC_RY: begin
        red <= cc; green <= xc; blue <= zc;
      end
      SEC_YG: begin
        red <= xc; green <= cc; blue <= zc;
      end
      SEC_GC: begin
        red <= zc; green <= cc; blue <= xc;
      end
      SEC_CB: begin
        red <= zc; green <= xc; blue <= cc;
      end
      SEC_BM: begin
        red <= xc; green <= zc; blue <= cc;
      end
      default: begin
        red <= cc; green <= zc; blue <= xc;
      end
    endcase
    alpha_out <= f_alp;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      a_vld <= accept;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
      done  <= f_vld;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst) a_vld |-> ##6 done)
    else $error("stage A item did not reach the output in six cycles");

  a_order: assert property (@(posedge clk) disable iff (rst)
    f_vld |-> (QW'(f_z) <= f_x) && (f_x <= QW'(f_c)))
    else $error("secondary component outside zero..chroma range");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (red <= ONE) && (green <= ONE) && (blue <= ONE) && (alpha_out <= ONE))
    else $error("channel above one");

endmodule

>>> hw/rtl/h2r_div15.sv
// Registered divide by fifteen through a reciprocal multiply.
module h2r_div15 import h2r_pkg::*; #(
  parameter int YW = 21
) (
  input  logic          clk,
  input  logic [YW-1:0] y,
  output logic [YW-4:0] q
);

  localparam int S  = YW + 4;
  localparam int RW = S - 3;
  localparam int PW = YW + RW;
  localparam logic [63:0] RECIP64 = ((64'd1 << S) + 64'd14) / 64'd15;
  localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

  logic [PW-1:0] prod;

  assign prod = PW'(y) * PW'(RECIP);

  always_ff @(posedge clk) begin
    q <= prod[PW-1:S];
  end

endmodule
